// ===== rtl/etw_pkg.sv =====
package etw_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_W = 16;
	localparam int REG_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int TOTAL_W = 48;
	localparam int WEIGHT_W = 32;

	localparam logic [REG_W-1:0] ROW_X_RST = 48'h0000_0000_1000;
	localparam logic [REG_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
	localparam logic [REG_W-1:0] ROW_Z_RST = 48'h1000_0000_0000;
	localparam logic [REG_W-1:0] EMISSION_RST = 48'h0;

	localparam logic [15:0] LUM_R = 16'd13933;
	localparam logic [15:0] LUM_G = 16'd46871;
	localparam logic [15:0] LUM_B = 16'd4732;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_X = 3'd0,
		REG_ROW_Y = 3'd1,
		REG_ROW_Z = 3'd2,
		REG_EMISSION = 3'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_XFORM,
		ST_CROSS,
		ST_SQUARE,
		ST_ROOT,
		ST_LUM,
		ST_WEIGHT,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] a_x;
		logic signed [FIELD_W-1:0] a_y;
		logic signed [FIELD_W-1:0] a_z;
		logic signed [FIELD_W-1:0] b_x;
		logic signed [FIELD_W-1:0] b_y;
		logic signed [FIELD_W-1:0] b_z;
		logic signed [FIELD_W-1:0] c_x;
		logic signed [FIELD_W-1:0] c_y;
		logic signed [FIELD_W-1:0] c_z;
	} tri_word_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] tri_weight;
		logic [TOTAL_W-1:0] running_total;
	} res_word_t;

	function automatic logic [1:0] next_axis(input logic [1:0] m);
		logic [1:0] n;
		case (m)
			2'd0: n = 2'd1;
			2'd1: n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/emissive_triangle_weight_cdf.sv =====
// Takes one triangle per word and returns one result word with its luminance-weighted area
// and the saturating running total. All multiplications share one registered multiplier,
// and the area root comes from a two-bit-per-cycle square-root unit.
// With C = COORD_BITS, each cross-product magnitude is squared in NC = ceil((2C+2)/16)
// 16-bit chunks and the area is weighted in NA = ceil((2C+1)/16) chunks; the
// block takes a new triangle only when the sequencer is back in its idle state.
module emissive_triangle_weight_cdf #(
	parameter int COORD_BITS = etw_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic tri_valid,
	output logic tri_ready,
	input etw_pkg::tri_word_t tri_word,
	output logic res_valid,
	input logic res_ready,
	output etw_pkg::res_word_t res_word,
	input logic cfg_we,
	input logic [etw_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [etw_pkg::REG_W-1:0] cfg_data
);
	import etw_pkg::*;

	localparam int C = COORD_BITS;
	localparam int M = (C + 1 > 17) ? C + 1 : 17;
	localparam int EW = C + 1;
	localparam int DW = C + 18;
	localparam int QW = DW - 12;
	localparam int XW = 2 * C + 3;
	localparam int MAGW = 2 * C + 2;
	localparam int NC = (MAGW + 15) / 16;
	localparam int SW = 4 * C + 4;
	localparam int RB = SW / 2;
	localparam int AW = RB - 1;
	localparam int NA = (AW + 15) / 16;
	localparam int PW = 16 * NA + 33;
	localparam int NCH = (NC > NA) ? NC : NA;
	localparam int CNW = (NCH > 2) ? $clog2(NCH) : 1;
	localparam logic signed [QW-1:0] QHI = QW'((64'sd1 <<< (C - 1)) - 64'sd1);
	localparam logic signed [QW-1:0] QLO = QW'(-(64'sd1 <<< (C - 1)));

	st_t state_q, state_n;
	logic ph_q;
	logic [1:0] k_q, r_q, t_q, m_q;
	logic [CNW-1:0] i_q, j_q;
	logic [REG_W-1:0] row_x_q, row_y_q, row_z_q, emis_q;
	logic [TOTAL_W-1:0] sum_q;
	logic res_valid_q;
	res_word_t res_q;

	logic signed [C-1:0] coord_q [9];
	logic signed [C-1:0] v0_q [3];
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [DW-1:0] dot_q;
	logic signed [XW-1:0] cross_q;
	logic [16*NC-1:0] mag_q;
	logic [SW-1:0] s_q;
	logic [31:0] lum_q;
	logic [PW-1:0] w_q;

	logic signed [M-1:0] op_a, op_b;
	logic signed [2*M-1:0] prod;
	logic [31:0] prod32;
	logic sq_start, sq_busy;
	logic [RB-1:0] root;
	logic [16*NA-1:0] area_ext;
	logic [3:0] cidx;
	logic [REG_W-1:0] row_sel;
	logic signed [DW-1:0] dsum;
	logic signed [C-1:0] vq;
	logic signed [XW-1:0] diff;
	logic [5+CNW:0] ofs;
	logic accept, res_load, sq_last, w_last;
	logic [WEIGHT_W-1:0] weight_c;
	logic [TOTAL_W:0] nsum;

	function automatic logic signed [C-1:0] fld(input logic [FIELD_W-1:0] f);
		logic [C+FIELD_W-1:0] z;
		z = (C + FIELD_W)'(f);
		return z[C-1:0];
	endfunction

	function automatic logic signed [C-1:0] sat_c(input logic signed [QW-1:0] q);
		logic signed [C-1:0] s;
		if (q > QHI) s = C'(QHI);
		else if (q < QLO) s = C'(QLO);
		else s = q[C-1:0];
		return s;
	endfunction

	etw_mul #(.M(M)) u_mul (.clk(clk), .a(op_a), .b(op_b), .p(prod));

	etw_sqrt #(.SW(SW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(s_q),
		.busy(sq_busy), .root(root)
	);

	assign prod32 = prod[31:0];
	assign area_ext = (16 * NA)'(root >> 1);
	assign cidx = 4'(k_q) * 4'd3 + 4'(t_q);
	assign ofs = (6 + CNW)'(16) * ((6 + CNW)'(i_q) + (6 + CNW)'(j_q));
	assign accept = tri_valid && tri_ready;
	assign tri_ready = (state_q == ST_IDLE);
	assign sq_last = (i_q == CNW'(NC - 1)) && (j_q == CNW'(NC - 1));
	assign w_last = (i_q == CNW'(NA - 1)) && (j_q == CNW'(1));
	assign weight_c = (|w_q[PW-1:64]) ? '1 : w_q[63:32];
	assign nsum = {1'b0, sum_q} + (TOTAL_W + 1)'(weight_c);
	assign dsum = ((t_q == 2'd0) ? DW'(0) : dot_q) + prod[DW-1:0];
	assign vq = sat_c(QW'(dsum >>> 12));
	assign diff = cross_q - XW'(prod);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (tri_valid) state_n = ST_XFORM;
			ST_XFORM: begin
				if (ph_q && t_q == 2'd2 && r_q == 2'd2 && k_q == 2'd2) state_n = ST_CROSS;
			end
			ST_CROSS: if (ph_q && t_q == 2'd1) state_n = ST_SQUARE;
			ST_SQUARE: begin
				if (ph_q && sq_last) state_n = (m_q == 2'd2) ? ST_ROOT : ST_CROSS;
			end
			ST_ROOT: if (ph_q && !sq_busy) state_n = ST_LUM;
			ST_LUM: if (ph_q && t_q == 2'd2) state_n = ST_WEIGHT;
			ST_WEIGHT: if (ph_q && w_last) state_n = ST_OUT;
			ST_OUT: if (!res_valid_q || res_ready) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		sq_start = 1'b0;
		res_load = 1'b0;
		row_sel = row_x_q;
		case (r_q)
			2'd1: row_sel = row_y_q;
			2'd2: row_sel = row_z_q;
			default: row_sel = row_x_q;
		endcase
		case (state_q)
			ST_XFORM: begin
				op_a = M'($signed(row_sel[16*t_q +: 16]));
				op_b = M'(coord_q[cidx]);
			end
			ST_CROSS: begin
				if (t_q == 2'd0) begin
					op_a = M'(e1_q[next_axis(m_q)]);
					op_b = M'(e2_q[next_axis(next_axis(m_q))]);
				end else begin
					op_a = M'(e1_q[next_axis(next_axis(m_q))]);
					op_b = M'(e2_q[next_axis(m_q)]);
				end
			end
			ST_SQUARE: begin
				op_a = M'(mag_q[16*i_q +: 16]);
				op_b = M'(mag_q[16*j_q +: 16]);
			end
			ST_ROOT: sq_start = !ph_q;
			ST_LUM: begin
				op_a = M'(emis_q[16*t_q +: 16]);
				case (t_q)
					2'd0: op_b = M'(LUM_R);
					2'd1: op_b = M'(LUM_G);
					default: op_b = M'(LUM_B);
				endcase
			end
			ST_WEIGHT: begin
				op_a = M'(area_ext[16*i_q +: 16]);
				op_b = M'(lum_q[16*j_q[0] +: 16]);
			end
			ST_OUT: res_load = !res_valid_q || res_ready;
			default: op_a = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q <= 1'b0;
			k_q <= '0;
			r_q <= '0;
			t_q <= '0;
			m_q <= '0;
			i_q <= '0;
			j_q <= '0;
			row_x_q <= ROW_X_RST;
			row_y_q <= ROW_Y_RST;
			row_z_q <= ROW_Z_RST;
			emis_q <= EMISSION_RST;
			sum_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				case (cfg_idx)
					REG_ROW_X: row_x_q <= cfg_data;
					REG_ROW_Y: row_y_q <= cfg_data;
					REG_ROW_Z: row_z_q <= cfg_data;
					REG_EMISSION: emis_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
				sum_q <= nsum[TOTAL_W] ? '1 : nsum[TOTAL_W-1:0];
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					ph_q <= 1'b0;
					k_q <= '0;
					r_q <= '0;
					t_q <= '0;
					m_q <= '0;
					i_q <= '0;
					j_q <= '0;
				end
				ST_XFORM: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (t_q == 2'd2) begin
							t_q <= '0;
							if (r_q == 2'd2) begin
								r_q <= '0;
								k_q <= k_q + 1'b1;
							end else begin
								r_q <= r_q + 1'b1;
							end
						end else begin
							t_q <= t_q + 1'b1;
						end
					end
				end
				ST_CROSS: begin
					ph_q <= !ph_q;
					if (ph_q) t_q <= (t_q == 2'd1) ? 2'd0 : t_q + 1'b1;
				end
				ST_SQUARE: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (j_q == CNW'(NC - 1)) begin
							j_q <= '0;
							if (i_q == CNW'(NC - 1)) begin
								i_q <= '0;
								m_q <= m_q + 1'b1;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_ROOT: begin
					if (!ph_q) ph_q <= 1'b1;
					else if (!sq_busy) ph_q <= 1'b0;
				end
				ST_LUM: begin
					ph_q <= !ph_q;
					if (ph_q) t_q <= (t_q == 2'd2) ? 2'd0 : t_q + 1'b1;
				end
				ST_WEIGHT: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (j_q == CNW'(1)) begin
							j_q <= '0;
							i_q <= (i_q == CNW'(NA - 1)) ? '0 : i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				default: ph_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coord_q[0] <= fld(tri_word.a_x);
			coord_q[1] <= fld(tri_word.a_y);
			coord_q[2] <= fld(tri_word.a_z);
			coord_q[3] <= fld(tri_word.b_x);
			coord_q[4] <= fld(tri_word.b_y);
			coord_q[5] <= fld(tri_word.b_z);
			coord_q[6] <= fld(tri_word.c_x);
			coord_q[7] <= fld(tri_word.c_y);
			coord_q[8] <= fld(tri_word.c_z);
			s_q <= '0;
			w_q <= '0;
		end
		if (ph_q) begin
			case (state_q)
				ST_XFORM: begin
					dot_q <= dsum;
					if (t_q == 2'd2) begin
						case (k_q)
							2'd0: v0_q[r_q] <= vq;
							2'd1: e1_q[r_q] <= EW'(vq) - EW'(v0_q[r_q]);
							default: e2_q[r_q] <= EW'(vq) - EW'(v0_q[r_q]);
						endcase
					end
				end
				ST_CROSS: begin
					if (t_q == 2'd0) begin
						cross_q <= XW'(prod);
					end else begin
						mag_q <= (16 * NC)'(MAGW'(diff[XW-1] ? -diff : diff));
					end
				end
				ST_SQUARE: s_q <= s_q + (SW'(prod32) << ofs);
				ST_LUM: lum_q <= ((t_q == 2'd0) ? 32'd0 : lum_q) + prod32;
				ST_WEIGHT: w_q <= w_q + (PW'(prod32) << ofs);
				default: ;
			endcase
		end
		if (res_load) begin
			res_q.tri_weight <= weight_c;
			res_q.running_total <= nsum[TOTAL_W] ? '1 : nsum[TOTAL_W-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res_word = res_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_XFORM)
		else $error("Accepted word did not start the transform.");
	a_total_covers_weight: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> res_word.running_total >= TOTAL_W'(res_word.tri_weight))
		else $error("Running total fell below the triangle weight.");
	a_root_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		sq_busy |-> state_q == ST_ROOT)
		else $error("Square-root unit busy outside its state.");
`endif
endmodule

// ===== rtl/etw_mul.sv =====
module etw_mul #(
	parameter int M = 17
) (
	input logic clk,
	input logic signed [M-1:0] a,
	input logic signed [M-1:0] b,
	output logic signed [2*M-1:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

// ===== rtl/etw_sqrt.sv =====
module etw_sqrt #(
	parameter int SW = 68
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [SW-1:0] value,
	output logic busy,
	output logic [SW/2-1:0] root
);
	localparam int RB = SW / 2;
	localparam int CW = (RB > 1) ? $clog2(RB) : 1;

	logic [SW-1:0] val_q;
	logic [RB:0] rem_q;
	logic [RB-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [RB+2:0] rem2;
	logic [RB+2:0] trial;
	logic take;

	assign rem2 = {rem_q, val_q[SW-1:SW-2]};
	assign trial = (RB + 3)'({root_q, 2'b01});
	assign take = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(RB - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[SW-3:0], 2'b00};
			if (take) begin
				rem_q <= (RB + 1)'(rem2 - trial);
				root_q <= {root_q[RB-2:0], 1'b1};
			end else begin
				rem_q <= (RB + 1)'(rem2);
				root_q <= {root_q[RB-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule
